>>> rtl/blpx_pkg.sv
package blpx_pkg;

    localparam int CoordBitsDef = 12;
    localparam int ColourBits   = 24;
    localparam int QueueDepth   = 4;

    // command codes carried on the input tuser
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd_e;

endpackage

>>> rtl/blpx_front.sv
module blpx_front #(
    parameter int COORD_BITS = blpx_pkg::CoordBitsDef
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  blpx_pkg::t_cmd_e                 i_kind,
    input  logic [COORD_BITS-1:0]            i_x_start,
    input  logic [COORD_BITS-1:0]            i_y_start,
    input  logic [COORD_BITS-1:0]            i_x_end,
    input  logic [COORD_BITS-1:0]            i_y_end,
    input  logic [blpx_pkg::ColourBits-1:0]  i_colour,
    output logic                             o_valid,
    input  logic                             i_ready,
    output blpx_pkg::t_cmd_e                 o_kind,
    output logic [COORD_BITS-1:0]            o_x_start,
    output logic [COORD_BITS-1:0]            o_y_start,
    output logic [COORD_BITS-1:0]            o_major_end,
    output logic [COORD_BITS-1:0]            o_span_major,
    output logic [COORD_BITS-1:0]            o_span_minor,
    output logic                             o_x_dec,
    output logic                             o_y_dec,
    output logic                             o_x_major,
    output logic [blpx_pkg::ColourBits-1:0]  o_colour
);

    logic                            r_valid;
    blpx_pkg::t_cmd_e                r_kind;
    logic [COORD_BITS-1:0]           r_x_start;
    logic [COORD_BITS-1:0]           r_y_start;
    logic [COORD_BITS-1:0]           r_major_end;
    logic [COORD_BITS-1:0]           r_span_major;
    logic [COORD_BITS-1:0]           r_span_minor;
    logic                            r_x_dec;
    logic                            r_y_dec;
    logic                            r_x_major;
    logic [blpx_pkg::ColourBits-1:0] r_colour;

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  x_major;
    logic                  load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // signed differences, one extra bit so no overflow
    assign dx = {i_x_end[COORD_BITS-1], i_x_end} - {i_x_start[COORD_BITS-1], i_x_start};
    assign dy = {i_y_end[COORD_BITS-1], i_y_end} - {i_y_start[COORD_BITS-1], i_y_start};
    assign adx = dx[COORD_BITS] ? COORD_BITS'(~dx + 1'b1) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(~dy + 1'b1) : dy[COORD_BITS-1:0];
    // x wins ties
    assign x_major = (adx >= ady);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (load) begin
            r_kind       <= i_kind;
            r_x_start    <= i_x_start;
            r_y_start    <= i_y_start;
            r_major_end  <= x_major ? i_x_end : i_y_end;
            r_span_major <= x_major ? adx : ady;
            r_span_minor <= x_major ? ady : adx;
            r_x_dec      <= dx[COORD_BITS];
            r_y_dec      <= dy[COORD_BITS];
            r_x_major    <= x_major;
            r_colour     <= i_colour;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_x_start    = r_x_start;
    assign o_y_start    = r_y_start;
    assign o_major_end  = r_major_end;
    assign o_span_major = r_span_major;
    assign o_span_minor = r_span_minor;
    assign o_x_dec      = r_x_dec;
    assign o_y_dec      = r_y_dec;
    assign o_x_major    = r_x_major;
    assign o_colour     = r_colour;

endmodule

>>> rtl/blpx_queue.sv
module blpx_queue #(
    parameter int DATA_W = 88,
    parameter int DEPTH  = blpx_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;

    logic push;
    logic pop;

    assign o_ready = (r_count != CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/blpx_back.sv
module blpx_back #(
    parameter int COORD_BITS = blpx_pkg::CoordBitsDef
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  blpx_pkg::t_cmd_e                 i_kind,
    input  logic [COORD_BITS-1:0]            i_x_start,
    input  logic [COORD_BITS-1:0]            i_y_start,
    input  logic [COORD_BITS-1:0]            i_major_end,
    input  logic [COORD_BITS-1:0]            i_span_major,
    input  logic [COORD_BITS-1:0]            i_span_minor,
    input  logic                             i_x_dec,
    input  logic                             i_y_dec,
    input  logic                             i_x_major,
    input  logic [blpx_pkg::ColourBits-1:0]  i_colour,
    output logic                             o_line_active,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [COORD_BITS-1:0]            o_pixel_x,
    output logic [COORD_BITS-1:0]            o_pixel_y,
    output logic [blpx_pkg::ColourBits-1:0]  o_colour,
    output logic                             o_last
);

    localparam int ErrW = COORD_BITS + 2;

    logic                            r_active;
    logic [COORD_BITS-1:0]           r_cur_x;
    logic [COORD_BITS-1:0]           r_cur_y;
    logic [COORD_BITS-1:0]           r_major_end;
    logic [ErrW-1:0]                 r_err;
    logic [COORD_BITS-1:0]           r_span_major;
    logic [COORD_BITS-1:0]           r_span_minor;
    logic                            r_x_dec;
    logic                            r_y_dec;
    logic                            r_x_major;
    logic [blpx_pkg::ColourBits-1:0] r_colour;

    logic                            r_out_valid;
    logic [COORD_BITS-1:0]           r_out_x;
    logic [COORD_BITS-1:0]           r_out_y;
    logic [blpx_pkg::ColourBits-1:0] r_out_colour;
    logic                            r_out_last;

    logic                  out_free;
    logic                  is_start;
    logic                  emit;
    logic                  last;
    logic                  err_pos;
    logic [COORD_BITS-1:0] major_pos;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;
    logic [COORD_BITS-1:0] n_cur_x;
    logic [COORD_BITS-1:0] n_cur_y;
    logic [ErrW-1:0]       n_err;
    logic [ErrW-1:0]       init_err;

    assign out_free = !r_out_valid || i_ready;
    assign is_start = (i_kind == blpx_pkg::CMD_START);
    // starts and idle steps never need the output slot
    assign o_ready  = is_start || !r_active || out_free;
    assign emit     = i_valid && o_ready && !is_start && r_active;

    assign major_pos = r_x_major ? r_cur_x : r_cur_y;
    assign last      = (major_pos == r_major_end);
    assign err_pos   = !r_err[ErrW-1] && (r_err != '0);
    assign step_x    = r_x_dec ? '1 : COORD_BITS'(1);
    assign step_y    = r_y_dec ? '1 : COORD_BITS'(1);

    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (r_x_major) begin
            n_cur_x = r_cur_x + step_x;
            if (err_pos) begin
                n_cur_y = r_cur_y + step_y;
            end
        end else begin
            n_cur_y = r_cur_y + step_y;
            if (err_pos) begin
                n_cur_x = r_cur_x + step_x;
            end
        end
        n_err = r_err + {2'b00, r_span_minor} - (err_pos ? {2'b00, r_span_major} : '0);
    end

    // minor span minus half the major span, truncated
    assign init_err = {2'b00, i_span_minor} - {3'b000, i_span_major[COORD_BITS-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_major_end  <= '0;
            r_err        <= '0;
            r_span_major <= '0;
            r_span_minor <= '0;
            r_x_dec      <= 1'b0;
            r_y_dec      <= 1'b0;
            r_x_major    <= 1'b0;
            r_colour     <= '0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_valid && is_start) begin
                r_active     <= 1'b1;
                r_cur_x      <= i_x_start;
                r_cur_y      <= i_y_start;
                r_major_end  <= i_major_end;
                r_err        <= init_err;
                r_span_major <= i_span_major;
                r_span_minor <= i_span_minor;
                r_x_dec      <= i_x_dec;
                r_y_dec      <= i_y_dec;
                r_x_major    <= i_x_major;
                r_colour     <= i_colour;
            end else if (emit) begin
                if (last) begin
                    r_active <= 1'b0;
                end else begin
                    r_cur_x <= n_cur_x;
                    r_cur_y <= n_cur_y;
                    r_err   <= n_err;
                end
            end
        end
        if (emit) begin
            r_out_x      <= r_cur_x;
            r_out_y      <= r_cur_y;
            r_out_colour <= r_colour;
            r_out_last   <= last;
        end
    end

    assign o_line_active = r_active;
    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_colour      = r_out_colour;
    assign o_last        = r_out_last;

endmodule

>>> rtl/bresenham_line_pixel_stepper_top.sv
// bresenham line stepper, all eight octants
//
// slave stream: tuser carries the command (0 starts a line, 1 asks for the
// next pixel); tdata carries the two endpoints and the colour. a start loads
// the line and gives no pixel, a step while idle gives nothing, a start in
// the middle of a line drops the old one.
// master stream: one pixel per step while a line is active, tlast on the
// second endpoint. a line gives major span plus one pixels.
//
// a slave transfer passes the classify register, the command queue and the
// pixel register before it shows up as a pixel on the master side. the block
// takes one transfer and gives one pixel per cycle while the receiver
// keeps up; the pixel stepper does its adds and compares combinationally.
// reset clears the queue, the current line and the output register. when the
// receiver stalls the pixel register holds, starts and idle steps drain from
// the queue, and s_axis_tready drops once queue and classify register fill.
module bresenham_line_pixel_stepper_top #(
    parameter int  COORD_BITS = blpx_pkg::CoordBitsDef,
    localparam int InW  = 4 * COORD_BITS + blpx_pkg::ColourBits,
    localparam int InTW = ((InW + 7) / 8) * 8,
    localparam int OutW  = 2 * COORD_BITS + blpx_pkg::ColourBits,
    localparam int OutTW = ((OutW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // x_start, y_start, x_end, y_end, line_colour_in
    input  logic [InTW-1:0]  s_axis_tdata,
    // command
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // pixel_x, pixel_y, pixel_colour
    output logic [OutTW-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam int CW  = COORD_BITS;
    localparam int ClW = blpx_pkg::ColourBits;
    localparam int QW  = 1 + 5 * CW + 3 + ClW;

    logic                    f_valid;
    logic                    f_ready;
    blpx_pkg::t_cmd_e        f_kind;
    blpx_pkg::t_cmd_e        in_kind;
    logic [CW-1:0]           f_x_start;
    logic [CW-1:0]           f_y_start;
    logic [CW-1:0]           f_major_end;
    logic [CW-1:0]           f_span_major;
    logic [CW-1:0]           f_span_minor;
    logic                    f_x_dec;
    logic                    f_y_dec;
    logic                    f_x_major;
    logic [ClW-1:0]          f_colour;

    logic                    q_valid;
    logic                    q_ready;
    logic [QW-1:0]           q_in;
    logic [QW-1:0]           q_out;
    blpx_pkg::t_cmd_e        q_kind;

    logic                    line_active;
    logic [CW-1:0]           px;
    logic [CW-1:0]           py;
    logic [ClW-1:0]          pcolour;

    assign in_kind = blpx_pkg::t_cmd_e'(s_axis_tuser);

    blpx_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_kind       (in_kind),
        .i_x_start    (s_axis_tdata[CW-1:0]),
        .i_y_start    (s_axis_tdata[2*CW-1:CW]),
        .i_x_end      (s_axis_tdata[3*CW-1:2*CW]),
        .i_y_end      (s_axis_tdata[4*CW-1:3*CW]),
        .i_colour     (s_axis_tdata[4*CW+ClW-1:4*CW]),
        .o_valid      (f_valid),
        .i_ready      (f_ready),
        .o_kind       (f_kind),
        .o_x_start    (f_x_start),
        .o_y_start    (f_y_start),
        .o_major_end  (f_major_end),
        .o_span_major (f_span_major),
        .o_span_minor (f_span_minor),
        .o_x_dec      (f_x_dec),
        .o_y_dec      (f_y_dec),
        .o_x_major    (f_x_major),
        .o_colour     (f_colour)
    );

    assign q_in = {f_colour, f_x_major, f_y_dec, f_x_dec, f_span_minor, f_span_major,
                   f_major_end, f_y_start, f_x_start, f_kind};

    blpx_queue #(
        .DATA_W (QW),
        .DEPTH  (blpx_pkg::QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_in),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_out)
    );

    assign q_kind = blpx_pkg::t_cmd_e'(q_out[0]);

    blpx_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .o_ready       (q_ready),
        .i_kind        (q_kind),
        .i_x_start     (q_out[CW:1]),
        .i_y_start     (q_out[2*CW:CW+1]),
        .i_major_end   (q_out[3*CW:2*CW+1]),
        .i_span_major  (q_out[4*CW:3*CW+1]),
        .i_span_minor  (q_out[5*CW:4*CW+1]),
        .i_x_dec       (q_out[5*CW+1]),
        .i_y_dec       (q_out[5*CW+2]),
        .i_x_major     (q_out[5*CW+3]),
        .i_colour      (q_out[QW-1:5*CW+4]),
        .o_line_active (line_active),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_pixel_x     (px),
        .o_pixel_y     (py),
        .o_colour      (pcolour),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = OutTW'({pcolour, py, px});

    // a step taken on an active line never overwrites a pixel still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready && q_kind == blpx_pkg::CMD_STEP && line_active)
            |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pixel register overwritten while stalled");

    // the pixel carries tlast exactly when the line went idle
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready && q_kind == blpx_pkg::CMD_STEP && line_active)
            |=> (m_axis_tvalid && (m_axis_tlast == !line_active)))
        else $error("tlast and line state disagree");

    // a step on an idle line produces nothing
    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready && q_kind == blpx_pkg::CMD_STEP && !line_active
            && m_axis_tready) |=> !m_axis_tvalid)
        else $error("pixel produced by idle step");

    // the queue hands commands on whenever it holds them and the line is idle
    a_idle_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !line_active) |-> q_ready)
        else $error("queue stalled while line idle");

endmodule

>>> dv/bresenham_line_pixel_stepper_top_tb.sv
`timescale 1ns / 100ps

module bresenham_line_pixel_stepper_top_tb;

    localparam int CW          = blpx_pkg::CoordBitsDef;
    localparam int COLOUR_W    = blpx_pkg::ColourBits;
    localparam int ERR_W       = CW + 2;
    localparam int IN_TW       = ((4 * CW + COLOUR_W + 7) / 8) * 8;
    localparam int OUT_TW      = ((2 * CW + COLOUR_W + 7) / 8) * 8;
    localparam int ITEM_TARGET = 850;
    localparam int LIMIT       = 400000;
    localparam int EDGE_STEPS  = 24;
    localparam int CMAX        = (1 << (CW - 1)) - 1;
    localparam int CMIN        = -(1 << (CW - 1));

    typedef struct packed {
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic [COLOUR_W-1:0]    colour;
        logic                   last;
    } t_pixel;

    typedef struct packed {
        blpx_pkg::t_cmd_e       cmd;
        int                     xs;
        int                     ys;
        int                     xe;
        int                     ye;
        logic [COLOUR_W-1:0]    colour;
        bit                     typed;
        bit                     pix_due;
        int                     px;
        int                     py;
        bit                     last;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // x_start, y_start, x_end, y_end, line_colour_in
    logic [IN_TW-1:0]  s_axis_tdata = '0;
    // command
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // pixel_x, pixel_y, pixel_colour
    logic [OUT_TW-1:0] m_axis_tdata;
    logic              m_axis_tlast;

    int     src_idle_pct = 28;
    int     dst_idle_pct = 46;
    int     n_errors = 0;
    int     n_items = 0;
    int     n_cycles = 0;
    t_pixel expected_pixels[$];

    // line state of the predictor
    logic signed [CW-1:0]    line_x = '0;
    logic signed [CW-1:0]    line_y = '0;
    logic signed [CW-1:0]    line_end_major = '0;
    logic signed [ERR_W-1:0] line_err = '0;
    logic [CW-1:0]           line_span_major = '0;
    logic [CW-1:0]           line_span_minor = '0;
    logic                    line_x_down = 1'b0;
    logic                    line_y_down = 1'b0;
    logic                    line_x_major = 1'b0;
    logic                    line_busy = 1'b0;
    logic [COLOUR_W-1:0]     line_colour = '0;

    bresenham_line_pixel_stepper_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit rasterize(input blpx_pkg::t_cmd_e cmd,
                                     input logic [IN_TW-1:0] data,
                                     output t_pixel pix);
        int xs, ys, xe, ye, dx, dy, mj, mn;
        bit at_end;
        pix = '0;
        if (cmd == blpx_pkg::CMD_START) begin
            xs = int'($signed(data[CW-1:0]));
            ys = int'($signed(data[2*CW-1:CW]));
            xe = int'($signed(data[3*CW-1:2*CW]));
            ye = int'($signed(data[4*CW-1:3*CW]));
            dx = xe - xs;
            dy = ye - ys;
            line_x_down = dx < 0;
            line_y_down = dy < 0;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            line_x_major = dx >= dy;
            mj = line_x_major ? dx : dy;
            mn = line_x_major ? dy : dx;
            line_span_major = CW'(mj);
            line_span_minor = CW'(mn);
            line_end_major = CW'(line_x_major ? xe : ye);
            line_err = ERR_W'(mn - mj / 2);
            line_x = CW'(xs);
            line_y = CW'(ys);
            line_colour = data[4*CW +: COLOUR_W];
            line_busy = 1'b1;
            return 1'b0;
        end
        if (!line_busy) return 1'b0;
        at_end = (line_x_major ? line_x : line_y) == line_end_major;
        pix = '{line_x, line_y, line_colour, at_end};
        if (at_end) begin
            line_busy = 1'b0;
            return 1'b1;
        end
        // minor axis moves only on a strictly positive error
        if (line_err > 0) begin
            if (line_x_major) begin
                line_y = line_y_down ? line_y - CW'(1) : line_y + CW'(1);
            end else begin
                line_x = line_x_down ? line_x - CW'(1) : line_x + CW'(1);
            end
            line_err = line_err - ERR_W'(line_span_major);
        end
        if (line_x_major) begin
            line_x = line_x_down ? line_x - CW'(1) : line_x + CW'(1);
        end else begin
            line_y = line_y_down ? line_y - CW'(1) : line_y + CW'(1);
        end
        line_err = line_err + ERR_W'(line_span_minor);
        return 1'b1;
    endfunction

    function automatic logic [IN_TW-1:0] pack_line(int xs, int ys, int xe, int ye,
                                                   logic [COLOUR_W-1:0] col);
        return IN_TW'({col, CW'(ye), CW'(xe), CW'(ys), CW'(xs)});
    endfunction

    function automatic logic [IN_TW-1:0] rand_bits();
        logic [95:0] w;
        w = {$urandom(), $urandom(), $urandom()};
        return IN_TW'(w);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(CMAX - CMIN)) + CMIN;
    endfunction

    function automatic int near_coord(int c, int reach);
        int d, e;
        d = int'($urandom_range(2 * reach)) - reach;
        e = c + d;
        if (e > CMAX || e < CMIN) e = c - d;
        return e;
    endfunction

    function automatic t_dir_row start_row(int xs, int ys, int xe, int ye,
                                           logic [COLOUR_W-1:0] col);
        return '{blpx_pkg::CMD_START, xs, ys, xe, ye, col, 1'b0, 1'b0, 0, 0, 1'b0};
    endfunction

    function automatic t_dir_row step_row(bit typed, bit due, int px, int py,
                                          logic [COLOUR_W-1:0] col, bit last);
        return '{blpx_pkg::CMD_STEP, 0, 0, 0, 0, col, typed, due, px, py, last};
    endfunction

    task automatic send_item(input blpx_pkg::t_cmd_e cmd, input logic [IN_TW-1:0] data,
                             output bit got, output t_pixel pix);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = rasterize(cmd, data, pix);
        n_items++;
    endtask

    task automatic issue(input blpx_pkg::t_cmd_e cmd, input logic [IN_TW-1:0] data);
        bit got;
        t_pixel pix;
        send_item(cmd, data, got, pix);
        if (got) expected_pixels.push_back(pix);
    endtask

    // step payloads are random, the block must ignore them
    task automatic run_line(int xs, int ys, int xe, int ye, logic [COLOUR_W-1:0] col,
                            int n_steps);
        issue(blpx_pkg::CMD_START, pack_line(xs, ys, xe, ye, col));
        for (int i = 0; i < n_steps; i++) issue(blpx_pkg::CMD_STEP, rand_bits());
    endtask

    task automatic random_line();
        int r, q, xs, ys, xe, ye, reach, span, n_steps;
        logic [COLOUR_W-1:0] col;
        r = int'($urandom_range(99));
        col = COLOUR_W'($urandom());
        if (r < 6) begin
            issue(blpx_pkg::t_cmd_e'($urandom_range(1)), rand_bits());
            return;
        end
        xs = rand_coord();
        ys = rand_coord();
        if (r < 14) begin
            // long line, abandoned early by the next start
            xe = rand_coord();
            ye = rand_coord();
            n_steps = int'($urandom_range(1, 40));
        end else begin
            reach = (r < 30) ? 40 : 8;
            xe = near_coord(xs, reach);
            ye = near_coord(ys, reach);
            span = (xe > xs ? xe - xs : xs - xe);
            if ((ye > ys ? ye - ys : ys - ye) > span) span = (ye > ys ? ye - ys : ys - ye);
            q = int'($urandom_range(9));
            if (q < 7) n_steps = span + 1;
            else if (q == 7) n_steps = int'($urandom_range(span));
            else n_steps = span + 1 + int'($urandom_range(1, 3));
        end
        run_line(xs, ys, xe, ye, col, n_steps);
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        logic signed [CW-1:0] got_x, got_y;
        logic [COLOUR_W-1:0] got_c;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_x = m_axis_tdata[CW-1:0];
            got_y = m_axis_tdata[2*CW-1:CW];
            got_c = m_axis_tdata[2*CW +: COLOUR_W];
            if (expected_pixels.size() == 0) begin
                $error("pixel with none expected: x %0d y %0d", got_x, got_y);
                n_errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (got_x !== want.x) begin
                    $error("pixel_x expected %0d got %0d", want.x, got_x);
                    n_errors++;
                end
                if (got_y !== want.y) begin
                    $error("pixel_y expected %0d got %0d", want.y, got_y);
                    n_errors++;
                end
                if (got_c !== want.colour) begin
                    $error("pixel_colour expected %06h got %06h", want.colour, got_c);
                    n_errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_pixel expected %0b got %0b", want.last, m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= LIMIT) begin
            $display("bresenham_line_pixel_stepper_top test failed");
            $finish;
        end
    end

    initial begin
        t_dir_row rows[$];
        bit got;
        t_pixel pix;
        int target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(step_row(1'b1, 1'b0, 0, 0, 24'h0, 1'b0));
        // degenerate lines at origin and CMIN, a short line at CMAX
        rows.push_back(start_row(0, 0, 0, 0, 24'hFFFFFF));
        rows.push_back(step_row(1'b1, 1'b1, 0, 0, 24'hFFFFFF, 1'b1));
        rows.push_back(step_row(1'b1, 1'b0, 0, 0, 24'h0, 1'b0));
        rows.push_back(start_row(CMIN, CMIN, CMIN, CMIN, 24'h000000));
        rows.push_back(step_row(1'b1, 1'b1, CMIN, CMIN, 24'h000000, 1'b1));
        rows.push_back(start_row(CMAX, CMAX, CMAX - 2, CMAX, 24'hA5A5A5));
        rows.push_back(step_row(1'b1, 1'b1, CMAX, CMAX, 24'hA5A5A5, 1'b0));
        rows.push_back(step_row(1'b1, 1'b1, CMAX - 1, CMAX, 24'hA5A5A5, 1'b0));
        rows.push_back(step_row(1'b1, 1'b1, CMAX - 2, CMAX, 24'hA5A5A5, 1'b1));
        // shallow line cut short by a steep one going down
        rows.push_back(start_row(0, 0, 5, 2, 24'h123456));
        rows.push_back(step_row(1'b0, 1'b0, 0, 0, 24'h0, 1'b0));
        rows.push_back(step_row(1'b0, 1'b0, 0, 0, 24'h0, 1'b0));
        rows.push_back(start_row(-3, 4, -1, -2, 24'h654321));
        for (int i = 0; i < 7; i++) rows.push_back(step_row(1'b0, 1'b0, 0, 0, 24'h0, 1'b0));
        // diagonal, x takes the tie
        rows.push_back(start_row(100, -100, 103, -97, 24'h0F0F0F));
        for (int i = 0; i < 4; i++) rows.push_back(step_row(1'b0, 1'b0, 0, 0, 24'h0, 1'b0));

        foreach (rows[i]) begin
            send_item(rows[i].cmd,
                      pack_line(rows[i].xs, rows[i].ys, rows[i].xe, rows[i].ye, rows[i].colour),
                      got, pix);
            if (rows[i].typed) begin
                if (rows[i].pix_due)
                    expected_pixels.push_back(t_pixel'{CW'(rows[i].px), CW'(rows[i].py),
                                                       rows[i].colour, rows[i].last});
            end else if (got) begin
                expected_pixels.push_back(pix);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 46 : 0;
            dst_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 28 : 0;
            target = n_items + ITEM_TARGET / 3;
            while (n_items < target) random_line();
            // full-range lines push the error term to its extremes
            if (ph == 1) run_line(CMIN, CMAX, CMAX, CMIN, COLOUR_W'($urandom()), EDGE_STEPS);
            if (ph == 2) run_line(0, CMIN, 1, CMAX, COLOUR_W'($urandom()), EDGE_STEPS);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("bresenham_line_pixel_stepper_top test passed");
        end else begin
            $display("bresenham_line_pixel_stepper_top test failed");
        end
        $finish;
    end

endmodule
